>>> rtl/pbrd_pkg.sv
// ----------------------------------------------------------------------------
// pbrd_pkg
// Shared types, constants and the Base64 character decode for the pitch-bend
// Base64 run-length decoder.
// ----------------------------------------------------------------------------
package pbrd_pkg;

  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned B64_W           = 6;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned SAMPLE_W        = 13;
  localparam int unsigned REPEAT_W        = 16;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // Segment separator '#'
  localparam logic [CHAR_W-1:0] SEP_CHAR   = 8'h23;
  localparam logic [CHAR_W-1:0] DIGIT_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] DIGIT_NINE = 8'h39;

  // Classification of one character
  typedef struct packed {
    logic               is_sep;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
    logic [B64_W-1:0]   b64;
  } char_class_t;

  // One result beat
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [REPEAT_W-1:0] repeat_count;
    logic                is_last;
  } result_t;

  // Base64 value of a character; anything outside the alphabet gives 0
  function automatic logic [B64_W-1:0] b64_decode(input logic [CHAR_W-1:0] c);
    logic [B64_W-1:0] v;
    v = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = B64_W'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = B64_W'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = B64_W'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 6'd62;
    end else if (c == 8'h2F) begin
      v = 6'd63;
    end
    return v;
  endfunction

endpackage

>>> rtl/pbrd_char_dec.sv
// ----------------------------------------------------------------------------
// pbrd_char_dec
// Classifies one character: separator, decimal digit and Base64 value.
// ----------------------------------------------------------------------------
module pbrd_char_dec (
  input  logic [pbrd_pkg::CHAR_W-1:0] char_i,
  output pbrd_pkg::char_class_t       class_o
);
  import pbrd_pkg::*;

  // Decode all classes in parallel
  always_comb begin
    class_o.is_sep   = (char_i == SEP_CHAR);
    class_o.is_digit = (char_i >= DIGIT_ZERO) && (char_i <= DIGIT_NINE);
    class_o.digit    = DIGIT_W'(char_i - DIGIT_ZERO);
    class_o.b64      = b64_decode(char_i);
  end

endmodule

>>> rtl/pbrd_core.sv
// ----------------------------------------------------------------------------
// pbrd_core
// Segment state, pair assembly, repeat count accumulation and result
// selection for one character per enabled cycle.
// ----------------------------------------------------------------------------
module pbrd_core #(
  parameter int unsigned COUNT_WIDTH = pbrd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  pbrd_pkg::char_class_t class_i,
  input  logic                  eos_i,
  output logic                  res_valid_o,
  output pbrd_pkg::result_t     res_o
);
  import pbrd_pkg::*;

  localparam int unsigned PROD_W = COUNT_WIDTH + 4;

  logic                   in_count_q, in_count_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [B64_W-1:0]       pend_hi_q, pend_hi_d;
  logic [COUNT_WIDTH-1:0] acc_q, acc_d;
  logic                   digits_done_q, digits_done_d;
  logic [SAMPLE_W-1:0]    last_sample_q, last_sample_d;
  logic                   have_sample_q, have_sample_d;

  logic [PROD_W-1:0]        acc_x;
  logic [PROD_W-1:0]        prod;
  logic [COUNT_WIDTH-1:0]   acc_sat;
  logic [2*B64_W-1:0]       pair;
  logic [SAMPLE_W-1:0]      neg_sample;

  // Count times ten plus digit, saturating at the all-ones count
  always_comb begin
    acc_x   = PROD_W'(acc_q);
    prod    = (acc_x << 3) + (acc_x << 1) + PROD_W'(class_i.digit);
    acc_sat = (prod[PROD_W-1:COUNT_WIDTH] != '0) ? {COUNT_WIDTH{1'b1}}
                                                 : prod[COUNT_WIDTH-1:0];
  end

  // Pair value, sign-extended to 13 bits and negated
  always_comb begin
    pair       = {pend_hi_q, class_i.b64};
    neg_sample = SAMPLE_W'(-{pair[2*B64_W-1], pair});
  end

  // Next state and result
  always_comb begin
    in_count_d    = in_count_q;
    pend_valid_d  = pend_valid_q;
    pend_hi_d     = pend_hi_q;
    acc_d         = acc_q;
    digits_done_d = digits_done_q;
    last_sample_d = last_sample_q;
    have_sample_d = have_sample_q;
    res_valid_o   = 1'b0;
    res_o.sample       = neg_sample;
    res_o.repeat_count = REPEAT_W'(1);
    res_o.is_last      = eos_i;

    if (!in_count_q) begin
      if (class_i.is_sep) begin
        // drop any lone first character and open a count segment
        pend_valid_d  = 1'b0;
        pend_hi_d     = '0;
        in_count_d    = 1'b1;
        acc_d         = '0;
        digits_done_d = 1'b0;
      end else if (pend_valid_q) begin
        last_sample_d = neg_sample;
        have_sample_d = 1'b1;
        pend_valid_d  = 1'b0;
        pend_hi_d     = '0;
        res_valid_o   = 1'b1;
      end else begin
        pend_valid_d = 1'b1;
        pend_hi_d    = class_i.b64;
      end
    end else begin
      if (!class_i.is_sep) begin
        if (!digits_done_q && class_i.is_digit) begin
          acc_d = acc_sat;
        end else begin
          digits_done_d = 1'b1;
        end
      end
      // close the count segment on separator or end of string
      if (class_i.is_sep || eos_i) begin
        if (have_sample_q && acc_d != '0) begin
          res_valid_o        = 1'b1;
          res_o.sample       = last_sample_q;
          res_o.repeat_count = REPEAT_W'(acc_d);
        end
        acc_d         = '0;
        digits_done_d = 1'b0;
        in_count_d    = 1'b0;
      end
    end

    // end of string: end marker if nothing else, then back to reset state
    if (eos_i) begin
      if (!res_valid_o) begin
        res_valid_o        = 1'b1;
        res_o.sample       = last_sample_q;
        res_o.repeat_count = '0;
      end
      in_count_d    = 1'b0;
      pend_valid_d  = 1'b0;
      pend_hi_d     = '0;
      acc_d         = '0;
      digits_done_d = 1'b0;
      last_sample_d = '0;
      have_sample_d = 1'b0;
    end
  end

  // State registers, advanced once per consumed character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_count_q    <= 1'b0;
      pend_valid_q  <= 1'b0;
      pend_hi_q     <= '0;
      acc_q         <= '0;
      digits_done_q <= 1'b0;
      last_sample_q <= '0;
      have_sample_q <= 1'b0;
    end else if (en_i) begin
      in_count_q    <= in_count_d;
      pend_valid_q  <= pend_valid_d;
      pend_hi_q     <= pend_hi_d;
      acc_q         <= acc_d;
      digits_done_q <= digits_done_d;
      last_sample_q <= last_sample_d;
      have_sample_q <= have_sample_d;
    end
  end

endmodule

>>> rtl/pitch_bend_base64_rle_decoder.sv
// ----------------------------------------------------------------------------
// pitch_bend_base64_rle_decoder
// Decodes a pitch-bend string of Base64 sample pairs and '#'-separated
// decimal repeat counts into (sample, repeat) beats.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Beat contents
//  s_axis   | in        | tdata[7:0] char_code, tlast end_of_string
//  m_axis   | out       | tdata[12:0] sample, tdata[28:13] repeat_count,
//           |           | tlast is_last
//
//  One character is taken per cycle while the output does not stall; each
//  character is held in the input register, its result in the output register.
//  The throughput is set by the state update in pbrd_core.
//  A character that gives no result is consumed without an output beat.
//  Output stall holds the output register; the input register then holds
//  and s_axis_tready_o drops. Reset clears the valid flags and the core state.
// ----------------------------------------------------------------------------
module pitch_bend_base64_rle_decoder #(
  parameter int unsigned COUNT_WIDTH = pbrd_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tlast_i,   // end_of_string
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [12:0] sample, [28:13] repeat_count
  output logic        m_axis_tlast_o    // is_last
);
  import pbrd_pkg::*;

  logic              in_valid_q;
  logic [CHAR_W-1:0] in_char_q;
  logic              in_eos_q;
  logic              out_valid_q;
  result_t           out_res_q;
  logic              advance;
  char_class_t       cls;
  logic              res_valid;
  result_t           res;

  // Consume the held character when the output register can take a result
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_eos_q  <= s_axis_tlast_i;
    end
  end

  pbrd_char_dec u_char_dec (
    .char_i  (in_char_q),
    .class_o (cls)
  );

  pbrd_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .class_i     (cls),
    .eos_i       (in_eos_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_res_q.repeat_count, out_res_q.sample};
  assign m_axis_tlast_o  = out_res_q.is_last;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pitch-bend Base64 run-length decoder. Strings
// are sent one character per beat; a predictor in the bench works out each
// expected beat and the checker compares every output beat field by field.
// ----------------------------------------------------------------------------
module testbench;
  import pbrd_pkg::*;

  localparam int unsigned    COUNT_W    = COUNT_WIDTH_DEF;
  localparam longint unsigned RUN_MAX   = (64'd1 << COUNT_W) - 64'd1;
  localparam int unsigned    CYCLE_CAP  = 400000;
  localparam int unsigned    DRAIN_WAIT = 12;
  localparam int unsigned    STALL_LEN  = 400;

  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_UPPER_Z = "Z";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_Z = "z";
  localparam logic [7:0] CH_PLUS    = "+";
  localparam logic [7:0] CH_SLASH   = "/";
  localparam logic [7:0] CH_MINUS   = "-";

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  logic        m_last;

  // Stimulus and checking state
  result_t     decoded_beats[$];
  logic [7:0]  line_chars[$];
  int          items_sent = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int          sender_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          stall_request = 0;
  int          stall_left = 0;

  // Decoder state held by the predictor
  bit              in_counts;
  bit              high_held;
  bit              digits_closed;
  bit              sample_seen;
  logic [5:0]      held_high;
  longint unsigned run_acc;
  logic [12:0]     prev_sample;

  pitch_bend_base64_rle_decoder #(
    .COUNT_WIDTH(COUNT_W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("FAIL pitch_bend_base64_rle_decoder");
      $finish;
    end
  end

  // Output ready: random idling, or a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each output beat with the oldest expected beat
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (decoded_beats.size() == 0) begin
        $error("unexpected beat: sample %0d repeat %0d last %0b",
               $signed(m_data[12:0]), m_data[28:13], m_last);
        mismatches = mismatches + 1;
      end else begin
        want = decoded_beats.pop_front();
        if (m_data[12:0] !== want.sample) begin
          $error("sample: expected %0d, got %0d",
                 $signed(want.sample), $signed(m_data[12:0]));
          mismatches = mismatches + 1;
        end
        if (m_data[28:13] !== want.repeat_count) begin
          $error("repeat_count: expected %0d, got %0d", want.repeat_count, m_data[28:13]);
          mismatches = mismatches + 1;
        end
        if (m_last !== want.is_last) begin
          $error("is_last: expected %0b, got %0b", want.is_last, m_last);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return 6'(c - CH_UPPER_A);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return 6'(c - CH_LOWER_A + 26);
    if (c >= DIGIT_ZERO && c <= DIGIT_NINE) return 6'(c - DIGIT_ZERO + 52);
    if (c == CH_PLUS) return 6'd62;
    if (c == CH_SLASH) return 6'd63;
    return 6'd0;
  endfunction

  function automatic logic [7:0] sextet_to_char(input int unsigned idx);
    if (idx < 26) return 8'(CH_UPPER_A + idx);
    if (idx < 52) return 8'(CH_LOWER_A + idx - 26);
    if (idx < 62) return 8'(DIGIT_ZERO + idx - 52);
    if (idx == 62) return CH_PLUS;
    return CH_SLASH;
  endfunction

  task automatic clear_decoder_state();
    in_counts     = 1'b0;
    high_held     = 1'b0;
    digits_closed = 1'b0;
    sample_seen   = 1'b0;
    held_high     = '0;
    run_acc       = 0;
    prev_sample   = '0;
  endtask

  // Close a count segment: repeat the last sample if there is a count to apply
  task automatic close_counts(input bit eos, inout result_t r, inout bit got);
    if (sample_seen && run_acc != 0) begin
      r.sample       = prev_sample;
      r.repeat_count = run_acc[15:0];
      r.is_last      = eos;
      got            = 1'b1;
    end
    run_acc       = 0;
    digits_closed = 1'b0;
    in_counts     = 1'b0;
  endtask

  // Advance the decoder state by one character and queue any beat it causes
  task automatic predict_char(input logic [7:0] c, input bit eos);
    result_t     r;
    bit          got;
    logic [11:0] pair;
    r   = '0;
    got = 1'b0;
    if (!in_counts) begin
      if (c == SEP_CHAR) begin
        high_held     = 1'b0;
        held_high     = '0;
        in_counts     = 1'b1;
        run_acc       = 0;
        digits_closed = 1'b0;
      end else if (high_held) begin
        pair        = {held_high, char_to_sextet(c)};
        prev_sample = 13'd0 - {pair[11], pair};
        sample_seen = 1'b1;
        high_held   = 1'b0;
        held_high   = '0;
        r.sample       = prev_sample;
        r.repeat_count = 16'd1;
        r.is_last      = eos;
        got            = 1'b1;
      end else begin
        high_held = 1'b1;
        held_high = char_to_sextet(c);
      end
    end else begin
      if (c == SEP_CHAR) begin
        close_counts(eos, r, got);
      end else if (!digits_closed && c >= DIGIT_ZERO && c <= DIGIT_NINE) begin
        run_acc = run_acc * 10 + (c - DIGIT_ZERO);
        if (run_acc > RUN_MAX) run_acc = RUN_MAX;
      end else begin
        digits_closed = 1'b1;
      end
    end
    // End of string: close the segment, fall back to an end marker
    if (eos) begin
      if (in_counts && !got) close_counts(1'b1, r, got);
      if (!got) begin
        r.sample       = prev_sample;
        r.repeat_count = 16'd0;
        r.is_last      = 1'b1;
        got            = 1'b1;
      end
      clear_decoder_state();
    end
    if (got) decoded_beats = {decoded_beats, r};
  endtask

  // Send one character; entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input bit eos);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= c;
    s_last  <= eos;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    @(negedge clk_i);
    predict_char(c, eos);
    items_sent = items_sent + 1;
  endtask

  // Append one character to the line being built
  task automatic add_char(input logic [7:0] c);
    line_chars = {line_chars, c};
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  // Send the assembled line as one string, end_of_string on its last beat
  task automatic send_line();
    int i;
    for (i = 0; i < line_chars.size(); i++) begin
      send_char(line_chars[i], i == line_chars.size() - 1);
    end
    line_chars.delete();
  endtask

  function automatic logic [7:0] random_digit();
    return 8'(DIGIT_ZERO + $urandom_range(9));
  endfunction

  // Mostly well-formed string: alternating data pairs and counts, random content
  task automatic build_random_line();
    int segs;
    int s;
    int n;
    int k;
    int kind;
    segs = $urandom_range(1, 6);
    for (s = 0; s < segs; s++) begin
      if (s != 0) add_char(SEP_CHAR);
      if (s % 2 == 0) begin
        n = 2 * $urandom_range(1, 4);
        if ($urandom_range(9) == 0) n = n - 1;
        for (k = 0; k < n; k++) begin
          if ($urandom_range(9) == 0) add_char(8'($urandom_range(255)));
          else add_char(sextet_to_char($urandom_range(63)));
        end
      end else begin
        kind = $urandom_range(11);
        case (kind)
          0: begin
            // empty count
          end
          1: begin
            for (k = 0; k < 6; k++) add_char(random_digit());
          end
          2: begin
            add_char(random_digit());
            add_char(sextet_to_char($urandom_range(51)));
            add_char(random_digit());
          end
          3: begin
            add_char(CH_MINUS);
            add_char(random_digit());
          end
          4: begin
            add_char(DIGIT_ZERO);
          end
          default: begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) add_char(random_digit());
          end
        endcase
      end
    end
    if ($urandom_range(7) == 0) add_char(SEP_CHAR);
  endtask

  // Noise: separators, digits and arbitrary bytes in any order
  task automatic build_noise_line();
    int n;
    int k;
    n = $urandom_range(1, 12);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0:       add_char(SEP_CHAR);
        1:       add_char(random_digit());
        default: add_char(8'($urandom_range(255)));
      endcase
    end
  endtask

  // Field extremes and each corner of the string format
  task automatic test_directed_cases();
    sender_idle_pct = 37;
    sink_idle_pct   = 87;
    // largest and smallest samples, saturating count on the last beat
    push_text("//gAf/#99999");
    send_line();
    // count with no sample, bytes outside the alphabet, empty count,
    // digits cut short by a sign, lone trailing character
    push_text("#5#");
    add_char(8'hFF);
    add_char(8'h00);
    push_text("##AB#-3#C");
    send_line();
  endtask

  task automatic test_random_strings(input int src_pct, input int dst_pct,
                                     input int item_goal);
    int first;
    sender_idle_pct = src_pct;
    sink_idle_pct   = dst_pct;
    first = items_sent;
    while (items_sent - first < item_goal) begin
      if ($urandom_range(9) == 0) build_noise_line();
      else build_random_line();
      send_line();
    end
  endtask

  // Hold off the output for a long stretch while characters keep coming
  task automatic test_output_backpressure();
    int k;
    sender_idle_pct = 0;
    // drop the last beat offered so it is not taken a second time
    s_valid <= 1'b0;
    @(posedge clk_i);
    stall_request = STALL_LEN;
    @(negedge clk_i);
    for (k = 0; k < 20; k++) begin
      add_char(sextet_to_char($urandom_range(63)));
      add_char(sextet_to_char($urandom_range(63)));
    end
    push_text("#7");
    send_line();
  endtask

  initial begin
    clear_decoder_state();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_random_strings(37, 87, 420);
    test_output_backpressure();
    test_random_strings(87, 37, 420);
    test_random_strings(0, 0, 420);
    s_valid <= 1'b0;

    // Drain the expected beats, then watch for stray ones
    while (decoded_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS pitch_bend_base64_rle_decoder");
    end else begin
      $display("FAIL pitch_bend_base64_rle_decoder");
    end
    $finish;
  end

endmodule
